FILE: design/lru_duplicate_id_filter_core_macros.svh
`ifndef LRU_DUPLICATE_ID_FILTER_CORE_MACROS_SVH
`define LRU_DUPLICATE_ID_FILTER_CORE_MACROS_SVH

// Clocked check that is ignored while reset is asserted.
`define LRUDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LRUDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/lrudf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lrudf_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned OCC_MAX    = (1 << OCC_W) - 1;
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W      = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int unsigned ENTRY_W    = ID_W + STAMP_W;

  localparam logic [STAMP_W-1:0] STAMP_CEIL = '1;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [OCC_W-1:0]   occ_t;

endpackage
`default_nettype wire

FILE: design/lrudf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lrudf_in_if;
  logic                      valid;
  logic                      ready;
  logic [lrudf_pkg::ID_W-1:0] message_id;

  modport source (output valid, output message_id, input ready);
  modport sink   (input valid, input message_id, output ready);
endinterface

interface lrudf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       seen_before;
  logic [lrudf_pkg::OCC_W-1:0] occupied_count;

  modport source (output valid, output seen_before, output occupied_count, input ready);
  modport sink   (input valid, input seen_before, input occupied_count, output ready);
endinterface
`default_nettype wire

FILE: design/lru_duplicate_id_filter_core.sv
// Each item walks the slot memory through its single read port to find a match, a free
// slot and a victim; the next item is accepted only after the current one is written.
// The result waits in an output register; the next item may enter while it waits.
// Reset (asynchronous, active low) clears the valid bits, the count and the tick at once;
// the slot memory holds no reset value and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module lru_duplicate_id_filter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lrudf_in_if.sink    in_i,
  lrudf_out_if.source out_o
);
  import lrudf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_e;

  state_e                state_q;
  id_t                   id_q;
  cnt_t                  rd_cnt_q;
  logic                  rd_vld_q;
  idx_t                  rd_idx_q;
  logic [ENTRY_W-1:0]    rdata_q;
  logic [ENTRY_W-1:0]    slot_mem_q [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;
  cnt_t                  count_q;
  stamp_t                tick_q;
  logic                  hit_q;
  idx_t                  hit_idx_q;
  logic                  free_q;
  idx_t                  free_idx_q;
  stamp_t                best_q;
  idx_t                  victim_q;
  logic                  out_valid_q;
  logic                  seen_q;
  occ_t                  occ_q;

  logic                  rd_issue;
  idx_t                  rd_addr;
  id_t                   rd_id;
  stamp_t                rd_stamp;
  logic                  rd_slot_valid;
  logic                  scan_last;
  logic                  wr_en;
  idx_t                  wr_idx;
  stamp_t                tick_d;
  cnt_t                  count_d;
  logic [CMP_W-1:0]      count_x;
  occ_t                  occ_d;

  assign rd_issue      = (state_q == S_SCAN) && (rd_cnt_q < cnt_t'(ENTRIES));
  assign rd_addr       = rd_cnt_q[IDX_W-1:0];
  assign rd_id         = rdata_q[ENTRY_W-1:STAMP_W];
  assign rd_stamp      = rdata_q[STAMP_W-1:0];
  assign rd_slot_valid = valid_q[rd_idx_q];
  assign scan_last     = rd_vld_q && (rd_idx_q == idx_t'(ENTRIES - 1));

  assign wr_en   = (state_q == S_WRITE) && (!out_valid_q || out_o.ready);
  assign wr_idx  = hit_q ? hit_idx_q : (free_q ? free_idx_q : victim_q);
  assign tick_d  = tick_q + stamp_t'(1);
  assign count_d = (!hit_q && free_q) ? count_q + cnt_t'(1) : count_q;
  assign count_x = CMP_W'(count_d);
  assign occ_d   = (count_x > CMP_W'(OCC_MAX)) ? occ_t'(OCC_MAX) : occ_t'(count_x);

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.seen_before    = seen_q;
  assign out_o.occupied_count = occ_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_idx] <= {id_q, tick_d};
    end
    rdata_q <= slot_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      id_q <= in_i.message_id;
    end
    if (in_i.valid && in_i.ready) begin
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      best_q     <= STAMP_CEIL;
      victim_q   <= '0;
    end else if (rd_vld_q) begin
      if (rd_slot_valid && (rd_id == id_q) && !hit_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!rd_slot_valid && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (rd_slot_valid && (rd_stamp < best_q)) begin
        best_q   <= rd_stamp;
        victim_q <= rd_idx_q;
      end
    end
    if (rd_issue) begin
      rd_idx_q <= rd_addr;
    end
    if (wr_en) begin
      seen_q <= hit_q;
      occ_q  <= occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      tick_q      <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
      if (rd_issue) begin
        rd_cnt_q <= rd_cnt_q + cnt_t'(1);
      end
      if (rd_vld_q) begin
        if (rd_slot_valid && (rd_id == id_q)) begin
          hit_q <= 1'b1;
        end
        if (!rd_slot_valid) begin
          free_q <= 1'b1;
        end
      end
      if (out_valid_q && out_o.ready && !wr_en) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            state_q  <= S_SCAN;
            rd_cnt_q <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (wr_en) begin
            state_q          <= S_IDLE;
            tick_q           <= tick_d;
            count_q          <= count_d;
            valid_q[wr_idx]  <= 1'b1;
            out_valid_q      <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`include "lru_duplicate_id_filter_core_macros.svh"

  `LRUDF_ASSERT(a_count_matches_valid, count_q == CNT_W'($countones(valid_q)),
                "occupied count differs from valid bits")
  `LRUDF_ASSERT(a_tick_steps_on_write, wr_en |=> (tick_q == $past(tick_d)),
                "tick did not advance on write")
  `LRUDF_ASSERT(a_slot_valid_after_write, wr_en |=> valid_q[$past(wr_idx)],
                "written slot not marked valid")
  `LRUDF_ASSERT_ALWAYS(a_idle_no_read_pending, (state_q == S_IDLE) |-> !rd_vld_q,
                       "read pending while idle")

endmodule
`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import lrudf_pkg::*;

  localparam int RANDOM_ITEMS   = 1780;
  localparam int TAIL_ITEMS     = 200;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 2000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic seen;
    occ_t occupancy;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lrudf_in_if  in_if ();
  lrudf_out_if out_if ();

  lru_duplicate_id_filter_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  id_t      cache_id    [ENTRIES] = '{default: '0};
  stamp_t   cache_stamp [ENTRIES] = '{default: '0};
  logic     cache_valid [ENTRIES] = '{default: 1'b0};
  stamp_t   cache_tick = '0;

  id_t      pending_ids[$];
  verdict_t expected_verdicts[$];
  int       mismatch_count = 0;
  int       results_seen = 0;
  int       hold_left = 0;
  int       stall_cycles = 0;

  // Looks the id up, records it the way the block does and returns the verdict.
  function automatic verdict_t predict_verdict(input id_t msg_id);
    verdict_t v;
    int       target;
    int       filled;
    stamp_t   oldest;
    v.seen = 1'b0;
    target = -1;
    filled = 0;
    for (int s = 0; s < ENTRIES; s++) begin
      if (!v.seen && cache_valid[s] && cache_id[s] == msg_id) begin
        cache_tick     = cache_tick + 1'b1;
        cache_stamp[s] = cache_tick;
        v.seen         = 1'b1;
      end
    end
    if (!v.seen) begin
      for (int s = 0; s < ENTRIES; s++) begin
        if (target < 0 && !cache_valid[s]) target = s;
      end
      if (target < 0) begin
        target = 0;
        oldest = STAMP_CEIL;
        for (int s = 0; s < ENTRIES; s++) begin
          if (cache_valid[s] && cache_stamp[s] < oldest) begin
            oldest = cache_stamp[s];
            target = s;
          end
        end
      end
      cache_tick          = cache_tick + 1'b1;
      cache_id[target]    = msg_id;
      cache_stamp[target] = cache_tick;
      cache_valid[target] = 1'b1;
    end
    for (int s = 0; s < ENTRIES; s++) begin
      if (cache_valid[s]) filled++;
    end
    v.occupancy = (filled > OCC_MAX) ? occ_t'(OCC_MAX) : occ_t'(filled);
    return v;
  endfunction

  function automatic void note_mismatch(input string what, input verdict_t want,
                                        input verdict_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t %s: expected seen=%0b count=%0d, got seen=%0b count=%0d", $realtime,
               what, want.seen, want.occupancy, got.seen, got.occupancy);
    end
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  int send_gap = 0;
  int send_pct = 10;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.message_id <= '0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_verdicts.push_back(predict_verdict(in_if.message_id));
      end
      if (!in_if.valid || in_if.ready) begin
        if ($urandom_range(0, 59) == 0) send_pct = pick_idle_pct();
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_ids.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (hold_left == 0 && pending_ids.size() >= TAIL_ITEMS &&
                     $urandom_range(0, 99) < send_pct) begin
          send_gap = $urandom_range(0, 16);
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid      <= 1'b1;
          in_if.message_id <= pending_ids.pop_front();
        end
      end
    end
  end

  int   recv_gap = 0;
  int   recv_pct = 10;
  logic hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      recv_gap = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) recv_pct = pick_idle_pct();
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else if (pending_ids.size() >= TAIL_ITEMS && $urandom_range(0, 99) < recv_pct) begin
        recv_gap = $urandom_range(0, 16);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.seen      = out_if.seen_before;
      got.occupancy = out_if.occupied_count;
      results_seen <= results_seen + 1;
      if (expected_verdicts.size() == 0) begin
        note_mismatch("result with no item pending", '0, got);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.seen !== want.seen || got.occupancy !== want.occupancy) begin
          note_mismatch("result differs", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("lru_duplicate_id_filter_core: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    id_t         pool [24];
    id_t         recent[$];
    id_t         candidate;
    int          pool_n;
    int unsigned pick;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.message_id = '0;
    out_if.ready     = 1'b0;

    // Extremes and a duplicate of each, then fill every slot, refresh one entry
    // and force two evictions of the least recently stamped slots.
    pending_ids.push_back(32'h0000_0000);
    pending_ids.push_back(32'hFFFF_FFFF);
    pending_ids.push_back(32'h0000_0000);
    pending_ids.push_back(32'hFFFF_FFFF);
    pending_ids.push_back(32'h5555_5555);
    pending_ids.push_back(32'hAAAA_AAAA);
    pending_ids.push_back(32'h8000_0000);
    pending_ids.push_back(32'h0000_0001);
    for (int k = 0; k < 10; k++) pending_ids.push_back(32'h1000_0000 + k);
    pending_ids.push_back(32'h0000_0000);
    pending_ids.push_back(32'h7FFF_FFFF);
    pending_ids.push_back(32'hFFFF_FFFF);

    pool_n = 8;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 200 == 0) begin
        pool_n = $urandom_range(6, 24);
        for (int j = 0; j < 24; j++) begin
          pool[j] = ($urandom_range(0, 3) == 0) ? id_t'($urandom_range(0, 31)) : $urandom();
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        candidate = pool[$urandom_range(0, pool_n - 1)];
      end else if (pick < 75 && recent.size() > 0) begin
        candidate = recent[$urandom_range(0, recent.size() - 1)];
      end else if (pick < 85) begin
        candidate = id_t'(1) << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) candidate = ~candidate;
      end else begin
        candidate = $urandom();
      end
      pending_ids.push_back(candidate);
      recent.push_back(candidate);
      if (recent.size() > 4) void'(recent.pop_front());
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ids.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 22) @(posedge clk_i);

    if (expected_verdicts.size() != 0) begin
      $display("%0d results never arrived", expected_verdicts.size());
      mismatch_count += expected_verdicts.size();
    end
    if (mismatch_count == 0) begin
      $display("lru_duplicate_id_filter_core: match");
    end else begin
      $display("lru_duplicate_id_filter_core: mismatch");
    end
    $finish;
  end

endmodule
